@@ rtl/lhm_pkg.sv @@
package lhm_pkg;

    localparam int unsigned TableDepthDefault = 16;

    localparam int unsigned CallW   = 48;
    localparam int unsigned ModuleW = 5;
    localparam int unsigned ModeW   = 2;
    localparam int unsigned LocW    = 48;
    localparam int unsigned PosW    = 64;
    localparam int unsigned StatusW = 2;
    localparam int unsigned RankW   = 4;
    localparam int unsigned OccW    = 5;

    typedef struct packed {
        logic [CallW-1:0]   source;
        logic [CallW-1:0]   destination;
        logic [CallW-1:0]   client;
        logic [ModuleW-1:0] module_req;
        logic [ModeW-1:0]   mode;
        logic [LocW-1:0]    locator;
        logic [PosW-1:0]    position;
    } t_entry;

    typedef enum logic [StatusW-1:0] {
        ST_UPDATED  = 2'd0,
        ST_INSERTED = 2'd1,
        ST_EVICTED  = 2'd2,
        ST_LOC_MISS = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ORD_RD,
        S_ENT_RD,
        S_CMP,
        S_MISS,
        S_WRITE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FRONT,
        S_DONE
    } t_state;

endpackage

@@ rtl/lhm_ram.sv @@
module lhm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/last_heard_mru_table.sv @@
// Last-heard table: a move-to-front list of up to TABLE_DEPTH stations.
//
// Command channel: drive the event fields and pulse start while busy is low;
// the transaction is taken at that edge and busy rises on the next cycle.
// Opcode 0 is a heard event (update or insert at the front, dropping the
// oldest entry when full); opcode 1 a location update (hit only).
//
// Result channel: o_valid is high for exactly one cycle with o_status,
// o_prior_rank and o_occupancy. The receiver cannot stall; it must take the
// result in that cycle. busy falls in the cycle after o_valid.
//
// From the accepting edge to the strobe, the search walks the ranks, each
// through an order read, an entry read and a compare; a miss passes the
// miss state, from which a location miss goes straight to the done state.
// Otherwise come the write, the reorder (a shift read and a shift write per
// rank moved), the front write and the done state. A full-table eviction is
// the worst case. The single port pair of the rank order memory sets the reorder cost.
//
// Reset clears only the entry count and the control; the memories hold
// garbage until written and no clearing pass is needed.
module last_heard_mru_table #(
    parameter int unsigned TABLE_DEPTH = lhm_pkg::TableDepthDefault
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_opcode,
    input  logic [lhm_pkg::CallW-1:0]      i_source,
    input  logic [lhm_pkg::CallW-1:0]      i_destination,
    input  logic [lhm_pkg::CallW-1:0]      i_client,
    input  logic [lhm_pkg::ModuleW-1:0]    i_module_req,
    input  logic [lhm_pkg::ModeW-1:0]      i_mode,
    input  logic [lhm_pkg::LocW-1:0]       i_locator,
    input  logic [lhm_pkg::PosW-1:0]       i_position,
    output logic                           o_valid,
    output logic [lhm_pkg::StatusW-1:0]    o_status,
    output logic [lhm_pkg::RankW-1:0]      o_prior_rank,
    output logic [lhm_pkg::OccW-1:0]       o_occupancy
);
    import lhm_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    t_state  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_rank, n_rank;
    logic [IW-1:0] r_pos, n_pos;
    logic [IW-1:0] r_slot, n_slot;
    logic          r_hit, n_hit;
    logic          r_opcode, n_opcode;
    t_status       r_status, n_status;
    t_entry        r_new, n_new;
    t_entry        r_ent, n_ent;

    // entry memory, indexed by physical slot
    logic          ent_we;
    logic [IW-1:0] ent_raddr;
    t_entry        ent_wdata, ent_rdata;

    // rank order memory: rank -> physical slot
    logic          ord_we;
    logic [IW-1:0] ord_waddr, ord_raddr, ord_wdata, ord_rdata;

    logic accept;
    logic last_rank;
    logic full;

    assign accept    = start && (r_state == S_IDLE);
    assign last_rank = (CW'(r_rank) == (r_count - CW'(1)));
    assign full      = (r_count == CW'(TABLE_DEPTH));

    lhm_ram #(.WIDTH($bits(t_entry)), .DEPTH(TABLE_DEPTH)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_slot),
        .i_wdata (ent_wdata),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    lhm_ram #(.WIDTH(IW), .DEPTH(TABLE_DEPTH)) u_ord_ram (
        .i_clk   (i_clk),
        .i_we    (ord_we),
        .i_waddr (ord_waddr),
        .i_wdata (ord_wdata),
        .i_raddr (ord_raddr),
        .o_rdata (ord_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = (r_count == '0) ? S_MISS : S_ORD_RD;
                end
            end
            S_ORD_RD:   n_state = S_ENT_RD;
            S_ENT_RD:   n_state = S_CMP;
            S_CMP: begin
                priority if (ent_rdata.source == r_new.source) n_state = S_WRITE;
                else if (last_rank) n_state = S_MISS;
                else n_state = S_ORD_RD;
            end
            S_MISS:     n_state = r_opcode ? S_DONE : S_WRITE;
            S_WRITE:    n_state = (r_pos == '0) ? S_FRONT : S_SHIFT_RD;
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = (r_pos == IW'(1)) ? S_FRONT : S_SHIFT_RD;
            S_FRONT:    n_state = S_DONE;
            S_DONE:     n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count   = r_count;
        n_rank    = r_rank;
        n_pos     = r_pos;
        n_slot    = r_slot;
        n_hit     = r_hit;
        n_opcode  = r_opcode;
        n_status  = r_status;
        n_new     = r_new;
        n_ent     = r_ent;
        ent_we    = 1'b0;
        ent_raddr = ord_rdata;
        ent_wdata = r_new;
        ord_we    = 1'b0;
        ord_waddr = r_pos;
        ord_wdata = ord_rdata;
        ord_raddr = r_rank;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rank               = '0;
                    n_hit                = 1'b0;
                    n_opcode             = i_opcode;
                    n_new.source         = i_source;
                    n_new.destination    = i_destination;
                    n_new.client         = i_client;
                    n_new.module_req     = i_module_req;
                    n_new.mode           = i_mode;
                    n_new.locator        = i_locator;
                    n_new.position       = i_position;
                end
            end
            S_ENT_RD: begin
                n_slot = ord_rdata;
            end
            S_CMP: begin
                if (ent_rdata.source == r_new.source) begin
                    n_hit    = 1'b1;
                    n_ent    = ent_rdata;
                    n_pos    = r_rank;
                    n_status = ST_UPDATED;
                end else if (!last_rank) begin
                    n_rank = r_rank + IW'(1);
                end
            end
            S_MISS: begin
                priority if (r_opcode) begin
                    n_status = ST_LOC_MISS;
                end else if (full) begin
                    // reuse the slot of the oldest entry, last read in the walk
                    n_status = ST_EVICTED;
                    n_pos    = IW'(TABLE_DEPTH - 1);
                end else begin
                    n_status = ST_INSERTED;
                    n_slot   = IW'(r_count);
                    n_pos    = IW'(r_count);
                    n_count  = r_count + CW'(1);
                end
            end
            S_WRITE: begin
                ent_we = 1'b1;
                priority if (!r_hit) begin
                    ent_wdata          = r_new;
                    ent_wdata.locator  = '0;
                    ent_wdata.position = '0;
                end else if (r_opcode) begin
                    ent_wdata          = r_ent;
                    ent_wdata.locator  = r_new.locator;
                    ent_wdata.position = r_new.position;
                end else begin
                    ent_wdata             = r_ent;
                    ent_wdata.destination = r_new.destination;
                    ent_wdata.client      = r_new.client;
                    ent_wdata.module_req  = r_new.module_req;
                    ent_wdata.mode        = r_new.mode;
                end
            end
            S_SHIFT_RD: begin
                ord_raddr = r_pos - IW'(1);
            end
            S_SHIFT_WR: begin
                ord_we    = 1'b1;
                ord_waddr = r_pos;
                ord_wdata = ord_rdata;
                n_pos     = r_pos - IW'(1);
            end
            S_FRONT: begin
                ord_we    = 1'b1;
                ord_waddr = '0;
                ord_wdata = r_slot;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rank   <= n_rank;
        r_pos    <= n_pos;
        r_slot   <= n_slot;
        r_hit    <= n_hit;
        r_opcode <= n_opcode;
        r_status <= n_status;
        r_new    <= n_new;
        r_ent    <= n_ent;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_DONE);
    assign o_status     = r_status;
    assign o_prior_rank = r_hit ? RankW'(r_rank) : '0;
    assign o_occupancy  = OccW'(r_count);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy)
        else $error("busy held after result");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction taken without going busy");

    a_occ_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_LOC_MISS)) |-> (r_count != '0))
        else $error("table empty after update or insert");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == $past(r_count) + CW'(1)))
        else $error("entry count moved by other than one");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lhm_pkg::*;

    localparam int unsigned Depth      = TableDepthDefault;
    localparam int unsigned StallLimit = 2000;

    // Predicted table, front at index 0; only slots below count are meaningful.
    class mru_scoreboard;
        t_entry      slots[Depth];
        int unsigned count;
        logic [StatusW-1:0] want_status[$];
        logic [RankW-1:0]   want_rank[$];
        logic [OccW-1:0]    want_occ[$];
        int unsigned errors;
        int unsigned hits, inserts, evictions, loc_misses;

        function void note_event(logic op, t_entry ev);
            int hit_at;
            t_entry moved;
            logic [StatusW-1:0] st;
            logic [RankW-1:0] rk;
            hit_at = -1;
            rk = '0;
            for (int i = 0; i < count; i++) begin
                if (hit_at < 0 && slots[i].source == ev.source) hit_at = i;
            end
            if (hit_at >= 0) begin
                moved = slots[hit_at];
                if (op == 1'b0) begin
                    moved.destination = ev.destination;
                    moved.client      = ev.client;
                    moved.module_req  = ev.module_req;
                    moved.mode        = ev.mode;
                end else begin
                    moved.locator  = ev.locator;
                    moved.position = ev.position;
                end
                for (int i = hit_at; i > 0; i--) slots[i] = slots[i-1];
                slots[0] = moved;
                st = ST_UPDATED;
                rk = hit_at[RankW-1:0];
                hits++;
            end else if (op == 1'b0) begin
                int last;
                if (count >= Depth) begin
                    st = ST_EVICTED;
                    last = Depth - 1;
                    evictions++;
                end else begin
                    st = ST_INSERTED;
                    last = count;
                    count++;
                    inserts++;
                end
                for (int i = last; i > 0; i--) slots[i] = slots[i-1];
                moved = ev;
                moved.locator  = '0;
                moved.position = '0;
                slots[0] = moved;
            end else begin
                st = ST_LOC_MISS;
                loc_misses++;
            end
            want_status.push_back(st);
            want_rank.push_back(rk);
            want_occ.push_back(count[OccW-1:0]);
        endfunction

        function void check_result(logic [StatusW-1:0] st, logic [RankW-1:0] rk,
                                   logic [OccW-1:0] occ);
            logic [StatusW-1:0] es;
            logic [RankW-1:0] er;
            logic [OccW-1:0] eo;
            if (want_status.size() == 0) begin
                $display("%0t: unexpected result status=%0d rank=%0d occ=%0d",
                         $time, st, rk, occ);
                errors++;
                return;
            end
            es = want_status.pop_front();
            er = want_rank.pop_front();
            eo = want_occ.pop_front();
            if (st !== es) begin
                $display("%0t: status expected %0d actual %0d", $time, es, st);
                errors++;
            end
            if (rk !== er) begin
                $display("%0t: prior_rank expected %0d actual %0d", $time, er, rk);
                errors++;
            end
            if (occ !== eo) begin
                $display("%0t: occupancy expected %0d actual %0d", $time, eo, occ);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_opcode;
    logic [CallW-1:0]   i_source;
    logic [CallW-1:0]   i_destination;
    logic [CallW-1:0]   i_client;
    logic [ModuleW-1:0] i_module_req;
    logic [ModeW-1:0]   i_mode;
    logic [LocW-1:0]    i_locator;
    logic [PosW-1:0]    i_position;
    logic               o_valid;
    logic [StatusW-1:0] o_status;
    logic [RankW-1:0]   o_prior_rank;
    logic [OccW-1:0]    o_occupancy;

    mru_scoreboard board;
    int unsigned   quiet_cycles;
    bit            idle_allowed;
    logic [CallW-1:0] key_pool[24];

    last_heard_mru_table #(.TABLE_DEPTH(Depth)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Results cannot be held off: check every strobe, and count silent cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_result(o_status, o_prior_rank, o_occupancy);
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > StallLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Hand one transaction to the block and hold until it is taken.
    task automatic send_event(logic op, t_entry ev);
        if (idle_allowed && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        start         <= 1'b1;
        i_opcode      <= op;
        i_source      <= ev.source;
        i_destination <= ev.destination;
        i_client      <= ev.client;
        i_module_req  <= ev.module_req;
        i_mode        <= ev.mode;
        i_locator     <= ev.locator;
        i_position    <= ev.position;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        board.note_event(op, ev);
        start <= 1'b0;
        // Advance past the edge where busy rises, so the next start waits for it.
        @(posedge i_clk);
    endtask

    // Random fields around a given key; heard-only or location-only fields still toggle.
    task automatic send_random(logic op, logic [CallW-1:0] key);
        t_entry ev;
        ev.source      = key;
        ev.destination = CallW'(rand64());
        ev.client      = CallW'(rand64());
        ev.module_req  = ModuleW'($urandom());
        ev.mode        = ModeW'($urandom());
        ev.locator     = LocW'(rand64());
        ev.position    = rand64();
        send_event(op, ev);
    endtask

    task automatic drain();
        while (board.want_status.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        t_entry ev;
        board = new();
        quiet_cycles = 0;
        idle_allowed = 1'b0;
        start = 1'b0;
        i_opcode = 1'b0;
        i_source = '0;
        i_destination = '0;
        i_client = '0;
        i_module_req = '0;
        i_mode = '0;
        i_locator = '0;
        i_position = '0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: location miss on empty table, extremes, front hit, full table.
        ev = '0;
        send_event(1'b1, ev);
        send_event(1'b0, ev);
        send_event(1'b0, ev);
        ev = '1;
        send_event(1'b0, ev);
        ev.module_req = 5'd31;
        ev.locator = '1;
        ev.position = '1;
        send_event(1'b1, ev);
        ev = '0;
        send_event(1'b0, ev);
        send_event(1'b1, ev);
        for (int i = 0; i < Depth + 2; i++) send_random(1'b0, 48'h100 + i);
        send_random(1'b0, 48'h100 + 2);
        send_random(1'b1, 48'h100 + 17);
        send_random(1'b1, 48'h0);

        drain();

        for (int i = 0; i < 24; i++) key_pool[i] = CallW'(rand64());
        idle_allowed = 1'b1;
        for (int n = 0; n < 850; n++) begin
            logic op;
            logic [CallW-1:0] key;
            if (n == 400) drain();
            if (n == 700) idle_allowed = 1'b0;
            op = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) key = CallW'(rand64());
            else key = key_pool[$urandom_range(0, 23)];
            send_random(op, key);
        end

        while (board.want_status.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Covered %0d hits, %0d inserts, %0d evictions, %0d location misses.",
                 board.hits, board.inserts, board.evictions, board.loc_misses);
        if (board.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
